/* src/ccs_pkg.sv */
// ----------------------------------------------------------------------------
// ccs_pkg
// shared types and constants for the comment stripper
// ----------------------------------------------------------------------------
package ccs_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_SLASH  = 3'd1,
		MODE_BLOCK  = 3'd2,
		MODE_BSTAR  = 3'd3,
		MODE_LINE   = 3'd4,
		MODE_SQ     = 3'd5,
		MODE_DQ     = 3'd6
	} lex_mode_t;

	// one queued request: a byte, optionally preceded by a held slash
	typedef struct packed {
		logic       two;
		logic [7:0] ch;
	} ccs_entry_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} ccs_qstat_t;

endpackage

/* src/c_comment_stripper_core.sv */
// ----------------------------------------------------------------------------
// c_comment_stripper_core
// source text byte stream filter that removes block and line comments
// ----------------------------------------------------------------------------
// One byte is accepted per clock while full is low. The classifier updates the
// lexical mode in the cycle of acceptance and posts an emit request to a
// four-entry queue; the output side turns each request into one or two bytes
// (a released slash followed by the byte), one byte per cycle from the output
// register while the consumer keeps popping, so a kept byte passes through
// the queue and the output register before it shows on the result ports.
// Dropped bytes produce no result. Input throughput is one byte per cycle;
// full rises only when the queue fills, under output back-pressure only.
// last marks the final output byte caused by one input byte.
module c_comment_stripper_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] char_out,
	output logic       last
);

	logic                take;
	logic                req_push;
	ccs_pkg::ccs_entry_t req_in, req_out;
	logic                req_pop;
	ccs_pkg::ccs_qstat_t qstat;

	assign full = qstat.full;
	assign take = push && !qstat.full;

	ccs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.char_in   (char_in),
		.req_push  (req_push),
		.req       (req_in)
	);

	ccs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (req_push),
		.wr_data (req_in),
		.pop     (req_pop),
		.rd_data (req_out),
		.stat    (qstat)
	);

	ccs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (!qstat.empty),
		.req       (req_out),
		.req_pop   (req_pop),
		.pop       (pop),
		.empty     (empty),
		.char_out  (char_out),
		.last      (last)
	);

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= ccs_pkg::QCNT_W'(ccs_pkg::QUEUE_DEPTH))
		else $error("request queue count beyond depth");

	a_nonlast_is_slash: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last) |-> (char_out == ccs_pkg::CH_SLASH))
		else $error("non-final output byte is not a released slash");

	a_pop_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_pop |-> (!qstat.empty && (empty || pop)))
		else $error("queue drained while output register blocked");
`endif

endmodule

/* src/ccs_front.sv */
// ----------------------------------------------------------------------------
// ccs_front
// lexical mode tracker, classifies each byte into an emit request
// ----------------------------------------------------------------------------
module ccs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                take,
	input  logic [7:0]          char_in,
	output logic                req_push,
	output ccs_pkg::ccs_entry_t req
);

	ccs_pkg::lex_mode_t mode_q, mode_d;
	logic               esc_q, esc_d;
	logic               strip_q;
	logic               emit;
	logic               is_quote;
	ccs_pkg::lex_mode_t quote_mode;
	logic [7:0]         closer;

	assign is_quote   = (char_in == ccs_pkg::CH_DQ) || (char_in == ccs_pkg::CH_SQ);
	assign quote_mode = (char_in == ccs_pkg::CH_DQ) ? ccs_pkg::MODE_DQ : ccs_pkg::MODE_SQ;
	assign closer     = (mode_q == ccs_pkg::MODE_DQ) ? ccs_pkg::CH_DQ : ccs_pkg::CH_SQ;

	// next state
	always_comb begin
		mode_d = mode_q;
		esc_d  = esc_q;
		unique case (mode_q)
			ccs_pkg::MODE_SLASH: begin
				if (char_in == ccs_pkg::CH_STAR) begin
					mode_d = ccs_pkg::MODE_BLOCK;
				end else if (char_in == ccs_pkg::CH_SLASH) begin
					if (strip_q) begin
						mode_d = ccs_pkg::MODE_LINE;
					end
				end else if (is_quote) begin
					mode_d = quote_mode;
					esc_d  = 1'b0;
				end else begin
					mode_d = ccs_pkg::MODE_NORMAL;
				end
			end
			ccs_pkg::MODE_BLOCK: begin
				if (char_in == ccs_pkg::CH_STAR) begin
					mode_d = ccs_pkg::MODE_BSTAR;
				end
			end
			ccs_pkg::MODE_BSTAR: begin
				if (char_in == ccs_pkg::CH_SLASH) begin
					mode_d = ccs_pkg::MODE_NORMAL;
				end else if (char_in != ccs_pkg::CH_STAR) begin
					mode_d = ccs_pkg::MODE_BLOCK;
				end
			end
			ccs_pkg::MODE_LINE: begin
				if (char_in == ccs_pkg::CH_NL) begin
					mode_d = ccs_pkg::MODE_NORMAL;
				end
			end
			ccs_pkg::MODE_SQ, ccs_pkg::MODE_DQ: begin
				if (char_in == ccs_pkg::CH_BSL) begin
					esc_d = ~esc_q;
				end else begin
					if (char_in == closer && !esc_q) begin
						mode_d = ccs_pkg::MODE_NORMAL;
					end
					esc_d = 1'b0;
				end
			end
			default: begin
				// normal text, also any unused code
				if (char_in == ccs_pkg::CH_SLASH) begin
					mode_d = ccs_pkg::MODE_SLASH;
				end else if (is_quote) begin
					mode_d = quote_mode;
					esc_d  = 1'b0;
				end else begin
					mode_d = ccs_pkg::MODE_NORMAL;
				end
			end
		endcase
	end

	// outputs
	always_comb begin
		emit     = 1'b0;
		req.two  = 1'b0;
		req.ch   = char_in;
		unique case (mode_q)
			ccs_pkg::MODE_SLASH: begin
				if (char_in == ccs_pkg::CH_SLASH) begin
					emit = !strip_q;
				end else if (char_in != ccs_pkg::CH_STAR) begin
					emit    = 1'b1;
					req.two = 1'b1;
				end
			end
			ccs_pkg::MODE_BLOCK, ccs_pkg::MODE_BSTAR: begin
				emit = 1'b0;
			end
			ccs_pkg::MODE_LINE: begin
				emit = (char_in == ccs_pkg::CH_NL);
			end
			ccs_pkg::MODE_SQ, ccs_pkg::MODE_DQ: begin
				emit = 1'b1;
			end
			default: begin
				emit = (char_in != ccs_pkg::CH_SLASH);
			end
		endcase
	end

	assign req_push = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ccs_pkg::MODE_NORMAL;
			esc_q   <= 1'b0;
			strip_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				strip_q <= cfg_wdata;
			end
			if (take) begin
				mode_q <= mode_d;
				esc_q  <= esc_d;
			end
		end
	end

endmodule

/* src/ccs_queue.sv */
// ----------------------------------------------------------------------------
// ccs_queue
// short request queue between classifier and output side
// ----------------------------------------------------------------------------
module ccs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ccs_pkg::ccs_entry_t wr_data,
	input  logic                pop,
	output ccs_pkg::ccs_entry_t rd_data,
	output ccs_pkg::ccs_qstat_t stat
);

	ccs_pkg::ccs_entry_t               mem_q [ccs_pkg::QUEUE_DEPTH];
	logic [ccs_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
	logic [ccs_pkg::QCNT_W-1:0]        count_q;
	logic                              do_push, do_pop;

	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == ccs_pkg::QCNT_W'(ccs_pkg::QUEUE_DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/ccs_back.sv */
// ----------------------------------------------------------------------------
// ccs_back
// expands queued requests into output bytes, holds the output register
// ----------------------------------------------------------------------------
module ccs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  ccs_pkg::ccs_entry_t req,
	output logic                req_pop,
	input  logic                pop,
	output logic                empty,
	output logic [7:0]          char_out,
	output logic                last
);

	logic       out_valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       phase_q;
	logic       load;
	logic       send_slash;

	assign load       = req_valid && (!out_valid_q || pop);
	assign send_slash = req.two && !phase_q;
	assign req_pop    = load && !send_slash;

	assign empty    = !out_valid_q;
	assign char_out = char_q;
	assign last     = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= send_slash ? ccs_pkg::CH_SLASH : req.ch;
			last_q <= !send_slash;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= send_slash;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
